### hdl/sbq_pkg.sv
// Types and constants shared by the stereo banded biquad filter.
`default_nettype none

package sbq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int Y_W       = 32;
  localparam int NUM_COEFS = 5;
  localparam int NUM_CH    = 2;
  localparam int CFG_IDX_W = 2;

  // Coefficient slots within a band.
  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ENABLE = 2'd1;

  // Channel numbers.
  localparam int CH_LEFT  = 0;
  localparam int CH_RIGHT = 1;

  localparam logic signed [15:0] OUT_MAX = 16'sd32767;
  localparam logic signed [15:0] OUT_MIN = -16'sd32768;

  typedef enum logic {
    OP_FILTER     = 1'b0,
    OP_COEF_WRITE = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic [2:0]                 band;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [2:0]                 coef_select;
    logic signed [COEF_W-1:0]   coef_value;
    logic                       frame_last;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       last;
  } result_t;

  // One history row: x[n-1], x[n-2], y[n-1], y[n-2] (y in Q.8).
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [Y_W-1:0]      y1;
    logic signed [Y_W-1:0]      y2;
  } hist_t;

endpackage

`default_nettype wire

### hdl/sbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/stereo_biquad_band_filter.sv
// A taken frame passes stage registers 1, 2 and 3, and then its result is registered.
// Throughput: one item per cycle while the output is not stalled; an item whose band matches
// a frame still in the three compute stages waits, so one band's rate is set by the history
// read-modify-write loop through the history RAM. Coefficient writes are stored when taken.
// Reset: enables go to 1 and all valid bits clear, so coefficients and histories read as
// zero until written; there is no clearing pass.
`default_nettype none

module stereo_biquad_band_filter
  import sbq_pkg::*;
#(
  parameter int BANDS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data
);

  localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

  localparam logic signed [37:0] Y_HI = 38'sd2147483647;
  localparam logic signed [37:0] Y_LO = -38'sd2147483648;
  localparam logic signed [23:0] O_HI = 24'sd32767;
  localparam logic signed [23:0] O_LO = -24'sd32768;

  // Configuration.
  logic left_enable;
  logic right_enable;
  logic [NUM_CH-1:0] ch_enable;

  assign cfg_ready = 1'b1;
  assign ch_enable[CH_LEFT]  = left_enable;
  assign ch_enable[CH_RIGHT] = right_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_enable  <= 1'b1;
      right_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEFT_ENABLE:  left_enable  <= cfg_data;
        CFG_RIGHT_ENABLE: right_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic s1_valid, s2_valid, s3_valid;
  logic r0, r1, r2, r3;
  logic hazard;
  logic item_acc, frame_acc, is_frame0, in_range0;
  logic [BW-1:0] addr0;
  logic [2:0] s1_band, s2_band, s3_band;

  assign r3 = !result_valid || !result_stall;
  assign r2 = !s3_valid || r3;
  assign r1 = !s2_valid || r2;
  assign r0 = !s1_valid || r1;

  // A frame in flight has not yet written back its band's history.
  assign hazard = (s1_valid && (s1_band == item.band)) ||
                  (s2_valid && (s2_band == item.band)) ||
                  (s3_valid && (s3_band == item.band));

  assign item_stall = !r0 || hazard;
  assign item_acc   = item_valid && !item_stall;
  assign is_frame0  = (item.opcode == OP_FILTER);
  assign frame_acc  = item_acc && is_frame0;
  assign in_range0  = ({29'd0, item.band} < 32'(BANDS));
  assign addr0      = BW'(item.band);

  // Coefficient storage: one RAM per coefficient slot, one row per band.
  logic [NUM_COEFS-1:0][BANDS-1:0] coef_vld;
  logic [NUM_COEFS-1:0]            coef_we;
  logic [COEF_W-1:0]               coef_rd [NUM_COEFS];

  for (genvar k = 0; k < NUM_COEFS; k++) begin : g_coef
    assign coef_we[k] = item_acc && !is_frame0 && in_range0 && (item.coef_select == 3'(k));

    sbq_ram #(.WIDTH(COEF_W), .DEPTH(BANDS)) u_coef_ram (
      .clk     (clk),
      .wr_en   (coef_we[k]),
      .wr_addr (addr0),
      .wr_data (item.coef_value),
      .rd_en   (frame_acc),
      .rd_addr (addr0),
      .rd_data (coef_rd[k])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        coef_vld[k] <= '0;
      end else if (coef_we[k]) begin
        coef_vld[k][addr0] <= 1'b1;
      end
    end
  end

  // History storage: one RAM per channel, one row per band.
  logic [NUM_CH-1:0][BANDS-1:0] hist_vld;
  logic [NUM_CH-1:0]            hist_we;
  hist_t                        hist_rd [NUM_CH];
  hist_t                        hist_wd [NUM_CH];
  logic [BW-1:0]                addr3;

  assign addr3 = BW'(s3_band);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_hist
    sbq_ram #(.WIDTH($bits(hist_t)), .DEPTH(BANDS)) u_hist_ram (
      .clk     (clk),
      .wr_en   (hist_we[c]),
      .wr_addr (addr3),
      .wr_data (hist_wd[c]),
      .rd_en   (frame_acc),
      .rd_addr (addr0),
      .rd_data (hist_rd[c])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        hist_vld[c] <= '0;
      end else if (hist_we[c]) begin
        hist_vld[c][addr3] <= 1'b1;
      end
    end
  end

  // Stage 1: RAM data arrives; form the five products per channel.
  logic                       s1_in_range, s1_last;
  logic signed [SAMPLE_W-1:0] s1_x [NUM_CH];
  logic [NUM_COEFS-1:0]       s1_coef_ok;
  logic [NUM_CH-1:0]          s1_hist_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (r0) begin
      s1_valid <= frame_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_acc) begin
      s1_band        <= item.band;
      s1_in_range    <= in_range0;
      s1_last        <= item.frame_last;
      s1_x[CH_LEFT]  <= item.left_sample;
      s1_x[CH_RIGHT] <= item.right_sample;
      for (int k = 0; k < NUM_COEFS; k++) begin
        s1_coef_ok[k] <= in_range0 && coef_vld[k][addr0];
      end
      for (int c = 0; c < NUM_CH; c++) begin
        s1_hist_ok[c] <= in_range0 && hist_vld[c][addr0];
      end
    end
  end

  logic signed [COEF_W-1:0] coef [NUM_COEFS];
  hist_t                    h1 [NUM_CH];
  logic signed [39:0]       p_b0 [NUM_CH];
  logic signed [39:0]       p_b1 [NUM_CH];
  logic signed [39:0]       p_b2 [NUM_CH];
  logic signed [55:0]       p_a1 [NUM_CH];
  logic signed [55:0]       p_a2 [NUM_CH];

  always_comb begin
    for (int k = 0; k < NUM_COEFS; k++) begin
      coef[k] = s1_coef_ok[k] ? $signed(coef_rd[k]) : '0;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      h1[c]   = s1_hist_ok[c] ? hist_rd[c] : '0;
      p_b0[c] = coef[COEF_B0] * s1_x[c];
      p_b1[c] = coef[COEF_B1] * h1[c].x1;
      p_b2[c] = coef[COEF_B2] * h1[c].x2;
      p_a1[c] = coef[COEF_A1] * h1[c].y1;
      p_a2[c] = coef[COEF_A2] * h1[c].y2;
    end
  end

  // Stage 2: feed-forward and feedback sums.
  logic                       s2_in_range, s2_last;
  logic signed [SAMPLE_W-1:0] s2_x [NUM_CH];
  logic signed [SAMPLE_W-1:0] s2_x1 [NUM_CH];
  logic signed [Y_W-1:0]      s2_y1 [NUM_CH];
  logic signed [39:0]         s2_b0 [NUM_CH];
  logic signed [39:0]         s2_b1 [NUM_CH];
  logic signed [39:0]         s2_b2 [NUM_CH];
  logic signed [55:0]         s2_a1 [NUM_CH];
  logic signed [55:0]         s2_a2 [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (r1) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && r1) begin
      s2_band     <= s1_band;
      s2_in_range <= s1_in_range;
      s2_last     <= s1_last;
      for (int c = 0; c < NUM_CH; c++) begin
        s2_x[c]  <= s1_x[c];
        s2_x1[c] <= h1[c].x1;
        s2_y1[c] <= h1[c].y1;
        s2_b0[c] <= p_b0[c];
        s2_b1[c] <= p_b1[c];
        s2_b2[c] <= p_b2[c];
        s2_a1[c] <= p_a1[c];
        s2_a2[c] <= p_a2[c];
      end
    end
  end

  logic signed [41:0] ff [NUM_CH];
  logic signed [56:0] fb [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ff[c] = s2_b0[c] + s2_b1[c] + s2_b2[c];
      fb[c] = s2_a1[c] + s2_a2[c];
    end
  end

  // Stage 3: scale, round toward zero, saturate; write back and register the result.
  logic                       s3_in_range, s3_last;
  logic signed [SAMPLE_W-1:0] s3_x [NUM_CH];
  logic signed [SAMPLE_W-1:0] s3_x1 [NUM_CH];
  logic signed [Y_W-1:0]      s3_y1 [NUM_CH];
  logic signed [41:0]         s3_ff [NUM_CH];
  logic signed [56:0]         s3_fb [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (r2) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && r2) begin
      s3_band     <= s2_band;
      s3_in_range <= s2_in_range;
      s3_last     <= s2_last;
      for (int c = 0; c < NUM_CH; c++) begin
        s3_x[c]  <= s2_x[c];
        s3_x1[c] <= s2_x1[c];
        s3_y1[c] <= s2_y1[c];
        s3_ff[c] <= ff[c];
        s3_fb[c] <= fb[c];
      end
    end
  end

  logic signed [57:0]         acc [NUM_CH];
  logic signed [57:0]         acc_adj [NUM_CH];
  logic signed [37:0]         q [NUM_CH];
  logic signed [Y_W-1:0]      y_new [NUM_CH];
  logic signed [Y_W-1:0]      y_adj [NUM_CH];
  logic signed [23:0]         o_wide [NUM_CH];
  logic signed [SAMPLE_W-1:0] o_sat [NUM_CH];
  logic signed [SAMPLE_W-1:0] o_sel [NUM_CH];
  logic [NUM_CH-1:0]          filt_en;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc[c] = (58'(s3_ff[c]) <<< 8) - 58'(s3_fb[c]);
      // Biasing a negative value before the arithmetic shift truncates toward zero.
      acc_adj[c] = (acc[c] < 0) ? (acc[c] + 58'sd1048575) : acc[c];
      q[c] = acc_adj[c][57:20];
      if (q[c] > Y_HI) begin
        y_new[c] = Y_HI[Y_W-1:0];
      end else if (q[c] < Y_LO) begin
        y_new[c] = Y_LO[Y_W-1:0];
      end else begin
        y_new[c] = q[c][Y_W-1:0];
      end
      y_adj[c]  = (y_new[c] < 0) ? (y_new[c] + 32'sd255) : y_new[c];
      o_wide[c] = y_adj[c][31:8];
      if (o_wide[c] > O_HI) begin
        o_sat[c] = OUT_MAX;
      end else if (o_wide[c] < O_LO) begin
        o_sat[c] = OUT_MIN;
      end else begin
        o_sat[c] = o_wide[c][SAMPLE_W-1:0];
      end
      filt_en[c] = s3_in_range && ch_enable[c];
      o_sel[c]   = filt_en[c] ? o_sat[c] : s3_x[c];
      hist_we[c] = s3_valid && r3 && filt_en[c];
      hist_wd[c].x1 = s3_x[c];
      hist_wd[c].x2 = s3_x1[c];
      hist_wd[c].y1 = y_new[c];
      hist_wd[c].y2 = s3_y1[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (r3) begin
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && r3) begin
      result.left_out  <= o_sel[CH_LEFT];
      result.right_out <= o_sel[CH_RIGHT];
      result.last      <= s3_last;
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the stereo banded biquad filter.
`timescale 1ns / 100ps

module tb
  import sbq_pkg::*;
();

  localparam int BANDS = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 200;
  localparam longint TIMEOUT_NS = 10_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [2:0] SEL_TOP = 3'd7;

  localparam logic signed [COEF_W-1:0] COEF_MAXV = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MINV = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic signed [COEF_W-1:0] ONE_Q20 = 24'sd1048576;
  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  // Shadow copy of the filter state.
  logic signed [COEF_W-1:0] coef_tbl [BANDS*NUM_COEFS];
  logic signed [SAMPLE_W-1:0] x_hist1 [BANDS*NUM_CH];
  logic signed [SAMPLE_W-1:0] x_hist2 [BANDS*NUM_CH];
  logic signed [Y_W-1:0] y_hist1 [BANDS*NUM_CH];
  logic signed [Y_W-1:0] y_hist2 [BANDS*NUM_CH];
  logic left_on = 1'b1;
  logic right_on = 1'b1;

  result_t expected_frames [$];
  int failures = 0;
  logic sender_gaps = 1'b0;
  logic receiver_gaps = 1'b0;
  logic hold_off_req = 1'b0;

  stereo_biquad_band_filter #(.BANDS(BANDS)) u_top (
    .clk,
    .rst,
    .item_valid,
    .item_stall,
    .item,
    .result_valid,
    .result_stall,
    .result,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [SAMPLE_W-1:0] biquad_step(input int bnd, input int ch,
                                                            input logic signed [SAMPLE_W-1:0] x);
    int h;
    int c;
    longint acc;
    longint y;
    longint s;
    h = bnd * NUM_CH + ch;
    c = bnd * NUM_COEFS;
    acc = 256 * (longint'(coef_tbl[c + COEF_B0]) * x
               + longint'(coef_tbl[c + COEF_B1]) * x_hist1[h]
               + longint'(coef_tbl[c + COEF_B2]) * x_hist2[h]);
    acc = acc - longint'(coef_tbl[c + COEF_A1]) * y_hist1[h]
              - longint'(coef_tbl[c + COEF_A2]) * y_hist2[h];
    // Integer division truncates toward zero, as the hardware does.
    y = acc / 1048576;
    if (y > Y_MAX) y = Y_MAX;
    else if (y < Y_MIN) y = Y_MIN;
    x_hist2[h] = x_hist1[h];
    x_hist1[h] = x;
    y_hist2[h] = y_hist1[h];
    y_hist1[h] = y[Y_W-1:0];
    s = y / 256;
    if (s > OUT_MAX) s = OUT_MAX;
    else if (s < OUT_MIN) s = OUT_MIN;
    return s[SAMPLE_W-1:0];
  endfunction

  function automatic void predict(input item_t it);
    result_t r;
    if (it.opcode == OP_COEF_WRITE) begin
      if (it.band < BANDS && it.coef_select <= COEF_A2)
        coef_tbl[it.band * NUM_COEFS + it.coef_select] = it.coef_value;
    end else begin
      r.left_out = it.left_sample;
      r.right_out = it.right_sample;
      r.last = it.frame_last;
      if (it.band < BANDS) begin
        if (left_on) r.left_out = biquad_step(int'(it.band), CH_LEFT, it.left_sample);
        if (right_on) r.right_out = biquad_step(int'(it.band), CH_RIGHT, it.right_sample);
      end
      expected_frames.push_back(r);
    end
  endfunction

  function automatic item_t random_item();
    item_t it;
    it = {$urandom, $urandom};
    return it;
  endfunction

  function automatic item_t make_frame(input logic [2:0] bnd, input logic signed [15:0] l,
                                       input logic signed [15:0] r, input logic lst);
    item_t it;
    it = random_item();
    it.opcode = OP_FILTER;
    it.band = bnd;
    it.left_sample = l;
    it.right_sample = r;
    it.frame_last = lst;
    return it;
  endfunction

  function automatic item_t make_write(input logic [2:0] bnd, input logic [2:0] sel,
                                       input logic signed [COEF_W-1:0] val);
    item_t it;
    it = random_item();
    it.opcode = OP_COEF_WRITE;
    it.band = bnd;
    it.coef_select = sel;
    it.coef_value = val;
    return it;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return OUT_MAX;
    if (r == 1) return OUT_MIN;
    if (r < 5) return SAMPLE_W'($urandom_range(0, 200) - 100);
    return SAMPLE_W'($urandom);
  endfunction

  // Coefficients of moderate size, so that most frames stay out of saturation.
  function automatic logic signed [COEF_W-1:0] sane_coef(input logic [2:0] sel);
    int span;
    span = (sel == COEF_A1) ? 2 ** 21 : 2 ** 19;
    return COEF_W'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic int pick_gap(input logic enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input item_t it);
    int n;
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict(it);
    n = pick_gap(sender_gaps);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and let every outstanding frame and write leave the pipeline.
  task automatic drain();
    item_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LEFT_ENABLE: left_on = d;
      CFG_RIGHT_ENABLE: right_on = d;
      default: ;
    endcase
  endtask

  task automatic set_enables(input logic l, input logic r);
    drain();
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 1'($urandom_range(0, 1)));
    write_reg(CFG_LEFT_ENABLE, l);
    write_reg(CFG_RIGHT_ENABLE, r);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_band(input logic [2:0] bnd);
    for (int s = COEF_B0; s <= COEF_A2; s++)
      send_item(make_write(bnd, 3'(s), sane_coef(3'(s))));
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    $error("%s: expected %0d, actual %0d", field, want, got);
    failures++;
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_frames.size() == 0) begin
        $error("result transfer with no frame waiting: left_out %0d, right_out %0d",
               result.left_out, result.right_out);
        failures++;
      end else begin
        want = expected_frames.pop_front();
        if (result.left_out !== want.left_out)
          report_mismatch("left_out", int'(want.left_out), int'(result.left_out));
        if (result.right_out !== want.right_out)
          report_mismatch("right_out", int'(want.right_out), int'(result.right_out));
        if (result.last !== want.last)
          report_mismatch("last", int'(want.last), int'(result.last));
      end
    end
  end

  // Drives result_stall; a long hold-off lets the pipeline fill up behind it.
  initial begin : result_backpressure
    int n;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        n = pick_gap(1'b1);
        result_stall <= 1'b1;
        repeat (n > 0 ? n : 1) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // With only b0 at unity, a filtered channel reproduces its input.
  task automatic test_unity_gain();
    send_item(make_write(3'd0, COEF_B0, ONE_Q20));
    send_item(make_frame(3'd0, OUT_MAX, OUT_MIN, 1'b0));
    send_item(make_frame(3'd0, OUT_MIN, OUT_MAX, 1'b1));
  endtask

  // Extreme coefficients drive both the output history and the samples into saturation.
  task automatic test_saturation();
    send_item(make_write(3'd7, COEF_B0, COEF_MAXV));
    send_item(make_write(3'd7, COEF_B1, COEF_MINV));
    send_item(make_write(3'd7, COEF_B2, COEF_MAXV));
    send_item(make_write(3'd7, COEF_A1, COEF_MINV));
    send_item(make_write(3'd7, COEF_A2, COEF_MAXV));
    send_item(make_frame(3'd7, OUT_MAX, OUT_MIN, 1'b0));
    send_item(make_frame(3'd7, OUT_MIN, OUT_MAX, 1'b1));
    send_item(make_frame(3'd7, 16'sd0, -16'sd1, 1'b0));
  endtask

  // Writes to slots past a2 must leave the band's coefficients at zero.
  task automatic test_ignored_writes();
    for (int s = COEF_A2 + 1; s <= SEL_TOP; s++)
      send_item(make_write(3'd1, 3'(s), COEF_MAXV));
    send_item(make_frame(3'd1, 16'sd1234, -16'sd1234, 1'b1));
    send_item(make_frame(3'd3, OUT_MAX, OUT_MIN, 1'b0));
  endtask

  // A disabled channel passes its sample and keeps its history untouched.
  task automatic test_enable_modes();
    for (int m = 0; m < 4; m++) begin
      set_enables(m[0], m[1]);
      send_item(make_frame(3'd0, rand_sample(), rand_sample(), 1'($urandom_range(0, 1))));
      send_item(make_frame(3'd7, rand_sample(), rand_sample(), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_random_traffic();
    int roll;
    for (int p = 0; p < 6; p++) begin
      set_enables(p != 1 && p != 4, p != 2 && p != 4);
      sender_gaps = (p % 3 != 0);
      receiver_gaps = (p % 2 == 1) || (p == 4);
      program_band(3'($urandom_range(0, BANDS - 1)));
      program_band(3'($urandom_range(0, BANDS - 1)));
      repeat (PHASE_ITEMS - 2 * NUM_COEFS) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          send_item(random_item());
        end else if (roll < 10) begin
          send_item(make_write(3'($urandom_range(0, BANDS - 1)),
                               3'($urandom_range(COEF_A2 + 1, SEL_TOP)), COEF_W'($urandom)));
        end else if (roll < 14) begin
          roll = $urandom_range(COEF_B0, COEF_A2);
          send_item(make_write(3'($urandom_range(0, BANDS - 1)), 3'(roll),
                               sane_coef(3'(roll))));
        end else begin
          send_item(make_frame(3'($urandom_range(0, BANDS - 1)), rand_sample(), rand_sample(),
                               1'($urandom_range(0, 1))));
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_enables(1'b1, 1'b1);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    program_band(3'd2);
    program_band(3'd5);
    hold_off_req = 1'b1;
    repeat (130) begin
      send_item(make_frame(3'($urandom_range(0, BANDS - 1)), rand_sample(), rand_sample(),
                           1'($urandom_range(0, 1))));
    end
  endtask

  initial begin : main
    foreach (coef_tbl[i]) coef_tbl[i] = '0;
    foreach (x_hist1[i]) begin
      x_hist1[i] = '0;
      x_hist2[i] = '0;
      y_hist1[i] = '0;
      y_hist2[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_unity_gain();
    test_saturation();
    test_ignored_writes();
    test_enable_modes();
    test_random_traffic();
    test_backpressure();
    drain();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
